FILE: hw/rtl/dgat_pkg.sv
`default_nettype none
package dgat_pkg;

    // default sizes
    localparam int DEF_TABLE_SLOTS     = 128;
    localparam int DEF_DEPS_PER_ACTION = 8;

    // field widths
    localparam int OP_W = 3;
    localparam int ID_W = 32;

    // op codes
    localparam logic [OP_W-1:0] OP_INIT     = 3'd0;
    localparam logic [OP_W-1:0] OP_SHUTDOWN = 3'd1;
    localparam logic [OP_W-1:0] OP_CREATE   = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD_DEP  = 3'd3;
    localparam logic [OP_W-1:0] OP_EXECUTE  = 3'd4;

    // stream payload widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    // one result item
    typedef struct packed {
        logic            ok;
        logic [ID_W-1:0] new_id;
    } t_result;

endpackage
`default_nettype wire

FILE: hw/rtl/dependency_gated_action_table.sv
// dependency gated action table
// commands enter on the s_axis channel, one transfer per command: op, action_id
// and dep_id packed in tdata. every command yields exactly one result transfer
// on the m_axis channel: ok and new_action_id packed in tdata.
// one command is worked on at a time; s_axis tready is high while the block
// is idle. the result sits in an output register, so the next command is
// taken while a finished result still waits for the receiver.
// init, shutdown and rejected ops go straight to the result; create walks the
// in-use marks for the lowest free slot; add dependency and execute look up the
// id by walking the slot memory one entry at a time (read, then compare), and
// execute repeats the lookup for each stored dependency in turn. the next
// command can be taken in the cycle after the result is loaded.
// a stalled receiver holds the result; the block then waits with the next
// result until the output register drains, and keeps s_axis tready low.
// reset disables the block, sets the id counter to 1 and clears every
// in-use mark; the id and dependency memories need no clearing pass.
`default_nettype none
module dependency_gated_action_table #(
    parameter int TABLE_SLOTS     = dgat_pkg::DEF_TABLE_SLOTS,
    parameter int DEPS_PER_ACTION = dgat_pkg::DEF_DEPS_PER_ACTION
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // op [2:0], action_id [34:3], dep_id [66:35], zero fill [71:67]
    input  wire  [dgat_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // ok [0], new_action_id [32:1], zero fill [39:33]
    output logic [dgat_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import dgat_pkg::*;

    localparam int SW  = $clog2(TABLE_SLOTS);
    localparam int CW  = $clog2(DEPS_PER_ACTION + 1);
    localparam int DW  = (DEPS_PER_ACTION > 1) ? $clog2(DEPS_PER_ACTION) : 1;
    localparam int WW  = ID_W + CW + 1;
    localparam int DEP_DEPTH = TABLE_SLOTS << DW;

    // state codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FREE    = 3'd1;
    localparam logic [2:0] ST_LK_RD   = 3'd2;
    localparam logic [2:0] ST_LK_CMP  = 3'd3;
    localparam logic [2:0] ST_DEP_RD  = 3'd4;
    localparam logic [2:0] ST_DEP_USE = 3'd5;
    localparam logic [2:0] ST_FIN     = 3'd6;

    // input fields
    logic [OP_W-1:0] in_op;
    logic [ID_W-1:0] in_action_id;
    logic [ID_W-1:0] in_dep_id;
    assign in_op        = i_s_axis_tdata[OP_W-1:0];
    assign in_action_id = i_s_axis_tdata[OP_W+ID_W-1:OP_W];
    assign in_dep_id    = i_s_axis_tdata[OP_W+2*ID_W-1:OP_W+ID_W];

    // memories: slot word is {done, dep count, id}
    logic [WW-1:0]   slot_mem [TABLE_SLOTS];
    logic [ID_W-1:0] dep_mem  [DEP_DEPTH];

    logic [2:0]             r_state, n_state;
    logic                   r_en, n_en;
    logic [ID_W-1:0]        r_ctr, n_ctr;
    logic [TABLE_SLOTS-1:0] r_in_use, n_in_use;
    logic                   r_is_exec, n_is_exec;
    logic                   r_phase, n_phase;
    logic [ID_W-1:0]        r_key, n_key;
    logic [ID_W-1:0]        r_dep, n_dep;
    logic [SW-1:0]          r_idx, n_idx;
    logic [SW-1:0]          r_tslot, n_tslot;
    logic [WW-1:0]          r_tword, n_tword;
    logic [CW-1:0]          r_d, n_d;
    t_result                r_res, n_res;

    logic [WW-1:0]   r_slot_rd;
    logic [ID_W-1:0] r_dep_rd;

    logic            slot_we;
    logic [SW-1:0]   slot_waddr;
    logic [WW-1:0]   slot_wdata;
    logic            dep_we;
    logic [SW+DW-1:0] dep_waddr;
    logic [ID_W-1:0] dep_wdata;

    logic            out_free;
    logic            out_load;
    logic            in_xfer;

    // fields of the word read back from the slot memory
    logic [ID_W-1:0] rd_id;
    logic [CW-1:0]   rd_cnt;
    logic            rd_done;
    logic [CW-1:0]   t_cnt;
    logic            last_idx;
    logic            hit;

    assign rd_id    = r_slot_rd[ID_W-1:0];
    assign rd_cnt   = r_slot_rd[ID_W+CW-1:ID_W];
    assign rd_done  = r_slot_rd[WW-1];
    assign t_cnt    = r_tword[ID_W+CW-1:ID_W];
    assign last_idx = (r_idx == SW'(TABLE_SLOTS - 1));
    assign hit      = r_in_use[r_idx] && (rd_id == r_key);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == ST_FIN) && out_free;

    // command sequencer
    always_comb begin
        n_state   = r_state;
        n_en      = r_en;
        n_ctr     = r_ctr;
        n_in_use  = r_in_use;
        n_is_exec = r_is_exec;
        n_phase   = r_phase;
        n_key     = r_key;
        n_dep     = r_dep;
        n_idx     = r_idx;
        n_tslot   = r_tslot;
        n_tword   = r_tword;
        n_d       = r_d;
        n_res     = r_res;
        slot_we    = 1'b0;
        slot_waddr = r_idx;
        slot_wdata = r_tword;
        dep_we     = 1'b0;
        dep_waddr  = {r_tslot, r_d[DW-1:0]};
        dep_wdata  = r_dep;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_res     = '0;
                    n_key     = in_action_id;
                    n_dep     = in_dep_id;
                    n_idx     = '0;
                    n_phase   = 1'b0;
                    n_d       = '0;
                    n_is_exec = (in_op == OP_EXECUTE);
                    n_state   = ST_FIN;
                    if (in_op == OP_INIT) begin
                        if (!r_en) begin
                            n_en     = 1'b1;
                            n_ctr    = ID_W'(1);
                            n_in_use = '0;
                        end
                        n_res.ok = 1'b1;
                    end else if (in_op == OP_SHUTDOWN) begin
                        n_en = 1'b0;
                    end else if (r_en && in_op == OP_CREATE) begin
                        n_state = ST_FREE;
                    end else if (r_en && (in_op == OP_ADD_DEP || in_op == OP_EXECUTE)) begin
                        n_state = ST_LK_RD;
                    end
                end
            end
            // walk the in-use marks for the lowest free slot
            ST_FREE: begin
                if (!r_in_use[r_idx]) begin
                    n_ctr           = r_ctr + ID_W'(1);
                    slot_we         = 1'b1;
                    slot_wdata      = {1'b0, {CW{1'b0}}, n_ctr};
                    n_in_use[r_idx] = 1'b1;
                    n_res.ok        = 1'b1;
                    n_res.new_id    = n_ctr;
                    n_state         = ST_FIN;
                end else if (last_idx) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            // read data arrives in the compare state
            ST_LK_RD: begin
                n_state = ST_LK_CMP;
            end
            ST_LK_CMP: begin
                if (hit) begin
                    if (!r_phase) begin
                        // target found
                        n_tslot = r_idx;
                        n_tword = r_slot_rd;
                        if (!r_is_exec) begin
                            if (rd_cnt < CW'(DEPS_PER_ACTION)) begin
                                dep_we     = 1'b1;
                                dep_waddr  = {r_idx, rd_cnt[DW-1:0]};
                                slot_we    = 1'b1;
                                slot_wdata = {rd_done, rd_cnt + CW'(1), rd_id};
                                n_res.ok   = 1'b1;
                            end
                            n_state = ST_FIN;
                        end else if (rd_cnt == '0) begin
                            slot_we    = 1'b1;
                            slot_wdata = {1'b1, rd_cnt, rd_id};
                            n_res.ok   = 1'b1;
                            n_state    = ST_FIN;
                        end else begin
                            n_state = ST_DEP_RD;
                        end
                    end else if (!rd_done) begin
                        n_state = ST_FIN;
                    end else if (r_d + CW'(1) == t_cnt) begin
                        // every dependency passed
                        slot_we    = 1'b1;
                        slot_waddr = r_tslot;
                        slot_wdata = {1'b1, r_tword[WW-2:0]};
                        n_res.ok   = 1'b1;
                        n_state    = ST_FIN;
                    end else begin
                        n_d     = r_d + CW'(1);
                        n_state = ST_DEP_RD;
                    end
                end else if (last_idx) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx   = r_idx + SW'(1);
                    n_state = ST_LK_RD;
                end
            end
            ST_DEP_RD: begin
                n_state = ST_DEP_USE;
            end
            // dependency id becomes the next lookup key
            ST_DEP_USE: begin
                n_key   = r_dep_rd;
                n_idx   = '0;
                n_phase = 1'b1;
                n_state = ST_LK_RD;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_en     <= 1'b0;
            r_ctr    <= ID_W'(1);
            r_in_use <= '0;
        end else begin
            r_state  <= n_state;
            r_en     <= n_en;
            r_ctr    <= n_ctr;
            r_in_use <= n_in_use;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_is_exec <= n_is_exec;
        r_phase   <= n_phase;
        r_key     <= n_key;
        r_dep     <= n_dep;
        r_idx     <= n_idx;
        r_tslot   <= n_tslot;
        r_tword   <= n_tword;
        r_d       <= n_d;
        r_res     <= n_res;
    end

    // slot memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_rd <= slot_mem[r_idx];
    end

    // dependency memory, rows of one slot
    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            dep_mem[dep_waddr] <= dep_wdata;
        end
        r_dep_rd <= dep_mem[{r_tslot, r_d[DW-1:0]}];
    end

    // result output stage
    dgat_out_reg u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (out_load),
        .i_res           (r_res),
        .o_free          (out_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/dgat_out_reg.sv
`default_nettype none
module dgat_out_reg (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_load,
    input  wire dgat_pkg::t_result             i_res,
    output logic                               o_free,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // ok [0], new_action_id [32:1], zero fill [39:33]
    output logic [dgat_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import dgat_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // slot is free when empty or being drained this cycle
    assign o_free = !r_valid || i_m_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload holds until the next load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - ID_W - 1){1'b0}}, r_res.new_id, r_res.ok};

endmodule
`default_nettype wire

FILE: sim/tb_dependency_gated_action_table.sv
module tb_dependency_gated_action_table;
    timeunit 1ns;
    timeprecision 1ps;
    import dgat_pkg::*;

    localparam int NSLOT     = DEF_TABLE_SLOTS;
    localparam int NDEP      = DEF_DEPS_PER_ACTION;
    localparam int IDLE_MAX  = 60000;
    localparam int ITEM_GOAL = 1300;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] aid;
        logic [ID_W-1:0] dep;
    } t_cmd;

    typedef struct {
        logic            ok;
        logic [ID_W-1:0] new_id;
    } t_resp;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    wire                    o_s_axis_tready;
    // op [2:0], action_id [34:3], dep_id [66:35], zero fill [71:67]
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    wire                    o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // ok [0], new_action_id [32:1], zero fill [39:33]
    wire  [OUT_TDATA_W-1:0] o_m_axis_tdata;

    dependency_gated_action_table uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // shadow of the action table
    bit              tbl_en;
    bit [ID_W-1:0]   tbl_ctr;
    bit              tbl_live [NSLOT];
    bit [ID_W-1:0]   tbl_id   [NSLOT];
    int              tbl_ndep [NSLOT];
    bit              tbl_done [NSLOT];
    bit [ID_W-1:0]   tbl_deps [NSLOT][NDEP];

    t_cmd  cmd_q[$];
    t_resp resp_q[$];
    t_cmd  cmd_held;
    int    errors;
    int    src_gap, snk_gap, idle_cnt;
    bit    src_burst, snk_burst;

    // generator view of the table
    bit              gen_en;
    bit [ID_W-1:0]   gen_ctr;
    bit [ID_W-1:0]   gen_first;
    int              gen_items;

    function automatic int find_live(bit [ID_W-1:0] id);
        for (int s = 0; s < NSLOT; s++)
            if (tbl_live[s] && tbl_id[s] == id) return s;
        return -1;
    endfunction

    // apply one command to the shadow table, return its result
    function automatic t_resp table_apply(t_cmd c);
        t_resp r;
        int    s, p;
        bit    pass;
        r.ok = 0;
        r.new_id = '0;
        if (c.op == OP_INIT) begin
            if (!tbl_en) begin
                tbl_en  = 1;
                tbl_ctr = 1;
                for (s = 0; s < NSLOT; s++) begin
                    tbl_live[s] = 0;
                    tbl_ndep[s] = 0;
                    tbl_done[s] = 0;
                end
            end
            r.ok = 1;
        end else if (c.op == OP_SHUTDOWN) begin
            tbl_en = 0;
        end else if (tbl_en && c.op == OP_CREATE) begin
            for (s = 0; s < NSLOT; s++)
                if (!tbl_live[s]) break;
            if (s < NSLOT) begin
                tbl_ctr     = tbl_ctr + 1;
                tbl_id[s]   = tbl_ctr;
                tbl_ndep[s] = 0;
                tbl_done[s] = 0;
                tbl_live[s] = 1;
                r.ok = 1;
                r.new_id = tbl_ctr;
            end
        end else if (tbl_en && c.op == OP_ADD_DEP) begin
            s = find_live(c.aid);
            if (s >= 0 && tbl_ndep[s] < NDEP) begin
                tbl_deps[s][tbl_ndep[s]] = c.dep;
                tbl_ndep[s]++;
                r.ok = 1;
            end
        end else if (tbl_en && c.op == OP_EXECUTE) begin
            s = find_live(c.aid);
            if (s >= 0) begin
                pass = 1;
                for (int d = 0; d < tbl_ndep[s]; d++) begin
                    p = find_live(tbl_deps[s][d]);
                    if (p < 0 || !tbl_done[p]) pass = 0;
                end
                if (pass) tbl_done[s] = 1;
                r.ok = pass;
            end
        end
        return r;
    endfunction

    // mostly no gap, some short, a few long; bursts with none at all
    function automatic int pick_gap(bit burst);
        int k;
        if (burst) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic push_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] aid, logic [ID_W-1:0] dep);
        t_cmd c;
        c.op  = op;
        c.aid = aid;
        c.dep = dep;
        cmd_q.push_back(c);
        gen_items++;
        if (op == OP_INIT && !gen_en) begin
            gen_en    = 1;
            gen_ctr   = 1;
            gen_first = 2;
        end else if (op == OP_SHUTDOWN) begin
            gen_en = 0;
        end else if (op == OP_CREATE && gen_en) begin
            gen_ctr++;
        end
    endtask

    // an id that most likely names a recent action
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 15) == 0) return $urandom;
        if (gen_ctr < gen_first) return gen_first;
        return $urandom_range(gen_first, gen_ctr);
    endfunction

    task automatic drain_all();
        while (cmd_q.size() != 0 || resp_q.size() != 0 || i_s_axis_tvalid)
            @(posedge i_clk);
    endtask

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // command source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 0;
            i_s_axis_tdata  <= '0;
            src_gap         <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                resp_q.push_back(table_apply(cmd_held));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if ($urandom_range(0, 199) == 0) src_burst = ~src_burst;
                if (src_gap > 0) begin
                    src_gap         <= src_gap - 1;
                    i_s_axis_tvalid <= 0;
                end else if (cmd_q.size() > 0) begin
                    cmd_held        = cmd_q.pop_front();
                    i_s_axis_tdata  <= {5'b0, cmd_held.dep, cmd_held.aid, cmd_held.op};
                    i_s_axis_tvalid <= 1;
                    src_gap         <= pick_gap(src_burst);
                end else begin
                    i_s_axis_tvalid <= 0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        t_resp want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 0;
            snk_gap         <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (resp_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual ok=%0b id=%h",
                             $time, o_m_axis_tdata[0], o_m_axis_tdata[32:1]);
                    errors++;
                end else begin
                    want = resp_q.pop_front();
                    if (o_m_axis_tdata[0] !== want.ok) begin
                        $display("%0t: ok mismatch, expected %0b actual %0b",
                                 $time, want.ok, o_m_axis_tdata[0]);
                        errors++;
                    end
                    if (o_m_axis_tdata[32:1] !== want.new_id) begin
                        $display("%0t: new_action_id mismatch, expected %h actual %h",
                                 $time, want.new_id, o_m_axis_tdata[32:1]);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0) snk_burst = ~snk_burst;
            if (snk_gap > 0) begin
                snk_gap         <= snk_gap - 1;
                i_m_axis_tready <= 0;
            end else begin
                i_m_axis_tready <= 1;
                snk_gap         <= pick_gap(snk_burst);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_MAX && (cmd_q.size() > 0 || resp_q.size() > 0
                                              || i_s_axis_tvalid)) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        int n;
        logic [ID_W-1:0] a;
        errors    = 0;
        idle_cnt  = 0;
        src_burst = 0;
        snk_burst = 0;
        gen_en    = 0;
        gen_ctr   = 1;
        gen_first = 2;
        gen_items = 0;
        tbl_en    = 0;
        tbl_ctr   = 1;
        for (int s = 0; s < NSLOT; s++) begin
            tbl_live[s] = 0;
            tbl_ndep[s] = 0;
            tbl_done[s] = 0;
        end
        i_rst_n         = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: disabled ops, init twice, deps, done chain, list full, bad ops
        push_cmd(OP_CREATE,  '0, '0);
        push_cmd(OP_ADD_DEP, 32'd2, 32'd3);
        push_cmd(OP_EXECUTE, 32'd2, '0);
        push_cmd(OP_SHUTDOWN, '1, '1);
        push_cmd(OP_INIT, '0, '0);
        push_cmd(OP_INIT, '1, '1);
        push_cmd(OP_CREATE, '0, '0);
        push_cmd(OP_CREATE, '0, '0);
        push_cmd(OP_ADD_DEP, 32'd3, 32'd2);
        push_cmd(OP_EXECUTE, 32'd3, '0);
        push_cmd(OP_EXECUTE, 32'd2, '0);
        push_cmd(OP_EXECUTE, 32'd3, '0);
        push_cmd(OP_EXECUTE, 32'd3, '0);
        push_cmd(OP_ADD_DEP, '1, 32'd2);
        push_cmd(OP_EXECUTE, '1, '0);
        for (int i = 0; i < NDEP + 1; i++)
            push_cmd(OP_ADD_DEP, 32'd2, i[0] ? '1 : 32'd3);
        push_cmd(OP_EXECUTE, 32'd2, '0);
        push_cmd(3'd5, '1, '1);
        push_cmd(3'd7, '1, '1);
        push_cmd(OP_SHUTDOWN, '0, '0);
        push_cmd(OP_CREATE, '0, '0);
        drain_all();

        // fill the table past full
        push_cmd(OP_INIT, '0, '0);
        for (int i = 0; i < NSLOT + 3; i++)
            push_cmd(OP_CREATE, $urandom, $urandom);
        push_cmd(OP_ADD_DEP, 32'd2 + NSLOT - 1, 32'd2);
        push_cmd(OP_EXECUTE, 32'd2 + NSLOT - 1, '0);
        push_cmd(OP_SHUTDOWN, '0, '0);
        drain_all();

        // random well-formed sessions with some noise
        while (gen_items < ITEM_GOAL) begin
            if (!gen_en || $urandom_range(0, 9) == 0) begin
                push_cmd(OP_SHUTDOWN, $urandom, $urandom);
                push_cmd(OP_INIT, $urandom, $urandom);
            end
            gen_first = gen_ctr + 1;
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                push_cmd(OP_CREATE, $urandom, $urandom);
            n = $urandom_range(0, 20);
            for (int i = 0; i < n; i++) begin
                a = pick_id();
                push_cmd(OP_ADD_DEP, a, pick_id());
            end
            n = $urandom_range(2, 25);
            for (int i = 0; i < n; i++)
                push_cmd(OP_EXECUTE, pick_id(), $urandom);
            if ($urandom_range(0, 3) == 0)
                push_cmd(OP_W'($urandom_range(0, 7)), $urandom, $urandom);
            if ($urandom_range(0, 7) == 0) drain_all();
            else while (cmd_q.size() >= 8) @(posedge i_clk);
        end

        drain_all();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/dgat_pkg.sv
hw/rtl/dgat_out_reg.sv
hw/rtl/dependency_gated_action_table.sv
sim/tb_dependency_gated_action_table.sv
